// ----- src/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the stream search-and-replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int REPLACE_MAX_DEF = 16;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN = 3'd5;

  // source of an emitted result
  typedef enum logic [1:0] {
    EMIT_WIN,
    EMIT_REP,
    EMIT_END
  } emit_sel_t;

  typedef struct packed {
    logic      load;      // write input byte into window
    logic      shift;     // drop oldest window byte, fill - 1
    logic      clr_fill;  // empty the window
    logic      rc_clr;    // reset replacement counter
    logic      rc_inc;    // advance replacement counter
    logic      emit;      // load the output register
    emit_sel_t emit_sel;
    logic      run_last;
  } ssr_cmd_t;

  typedef struct packed {
    logic full;       // fill equals pattern length
    logic hit;        // window equals pattern
    logic fill_zero;
    logic rc_last;    // replacement counter on the final byte
    logic rlen_zero;
    logic slot_free;  // output register can take a result
  } ssr_status_t;

endpackage

// ----- src/ssr_in_if.sv -----
// ----------------------------------------------------------------------------
// ssr_in_if
// Input byte channel: valid/ready with byte and end-of-stream flag.
// ----------------------------------------------------------------------------
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- src/ssr_out_if.sv -----
// ----------------------------------------------------------------------------
// ssr_out_if
// Result channel: valid/ready with output byte and framing flags.
// ----------------------------------------------------------------------------
interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input stream_end, output ready);
endinterface

// ----- src/ssr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ssr_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface ssr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/stream_search_replace_core.sv -----
// ----------------------------------------------------------------------------
// stream_search_replace_core
// Streaming find-and-replace: every leftmost non-overlapping occurrence of
// a 1..16 byte pattern is replaced by a 0..16 byte replacement.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Payload                                      | Handshake
// --------+-----+----------------------------------------------+-----------
// in_ch   | in  | in_byte[7:0], end_of_input                   | valid/ready
// out_ch  | out | out_byte[7:0], byte_valid, run_last, stream_end | valid/ready
// cfg_ch  | in  | index[2:0], data[63:0]                       | valid/ready
//
// Sequence: each byte is accepted, then the window is compared; a match then
//   emits the replacement bytes in order. The final byte then flushes the
//   bytes left in the window, sees the window empty and emits the marker;
//   after a match only the marker follows.
// The sequencer handles one transaction at a time; the output register
//   lets the next byte be taken while a result waits downstream.
// Reset (rst_n, sync, active low): window empty, pattern length 1,
//   replacement empty; no clearing pass.
// Stalls: out_ch.ready low holds the sequencer in its emitting state.
// cfg_ch is always ready; the user makes writes only when idle, unchecked.
// ----------------------------------------------------------------------------
module stream_search_replace_core #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ssr_in_if.sink   in_ch,
  ssr_out_if.source out_ch,
  ssr_cfg_if.sink  cfg_ch
);
  import ssr_pkg::*;

  ssr_cmd_t    cmd;
  ssr_status_t st;

  // config writes never stall
  assign cfg_ch.ready = 1'b1;

  // sequencer: accepts a byte, then steps through compare / burst / flush
  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_end   (in_ch.end_of_input),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // window, comparator, config and the output register
  ssr_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_byte        (in_ch.in_byte),
    .cfg_we         (cfg_ch.valid),
    .cfg_idx        (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_byte       (out_ch.out_byte),
    .out_byte_valid (out_ch.byte_valid),
    .out_run_last   (out_ch.run_last),
    .out_stream_end (out_ch.stream_end)
  );

`ifndef ASSERT_OFF
  // one transaction in flight: no back-to-back input accepts
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while previous transaction in progress");

  // end marker is a bare marker and closes the transaction
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stream_end |-> !out_ch.byte_valid && out_ch.run_last)
    else $error("malformed end marker");

  // pattern length write empties the window
  a_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready && cfg_ch.index == CFG_PAT_LEN |=> st.fill_zero)
    else $error("window not cleared on pattern length write");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.slot_free)
    else $error("result loaded over a pending result");
`endif

endmodule

// ----- src/ssr_datapath.sv -----
// ----------------------------------------------------------------------------
// ssr_datapath
// Config registers, match window, comparator, replacement counter and
// output register.
// ----------------------------------------------------------------------------
module ssr_datapath #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssr_pkg::ssr_cmd_t                  cmd,
  output ssr_pkg::ssr_status_t               st,
  input  logic [7:0]                         in_byte,
  input  logic                               cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic                               out_run_last,
  output logic                               out_stream_end
);
  import ssr_pkg::*;

  localparam int FW   = $clog2(PATTERN_MAX + 1);
  localparam int RC_W = $clog2(REPLACE_MAX + 1);
  localparam logic [LEN_W-1:0] PMAX_L = LEN_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0] RMAX_L = LEN_W'(REPLACE_MAX);

  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [LEN_W-1:0]      plen_r, rlen_r;
  logic [7:0]            win_r [PATTERN_MAX];
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [RC_W-1:0]       rc_r, rc_nxt;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_bv_r, out_rl_r, out_se_r;

  logic [2*CFG_DATA_W-1:0] pat_vec, rep_vec;
  logic [LEN_W-1:0]        plen_eff, rlen_eff, wr_pos;
  logic [PATTERN_MAX-1:0]  match;
  logic [7:0]              rep_byte;

  assign pat_vec = {pat_hi_r, pat_lo_r};
  assign rep_vec = {rep_hi_r, rep_lo_r};

  // zero means one, oversize saturates
  always_comb begin
    if (plen_r == '0) begin
      plen_eff = LEN_W'(1);
    end else if (plen_r > PMAX_L) begin
      plen_eff = PMAX_L;
    end else begin
      plen_eff = plen_r;
    end
    rlen_eff = (rlen_r > RMAX_L) ? RMAX_L : rlen_r;
  end

  // overfull window restarts at slot zero
  assign wr_pos   = (LEN_W'(fill_r) >= plen_eff) ? '0 : LEN_W'(fill_r);
  assign rep_byte = rep_vec[8*(4'(rc_r)) +: 8];

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
    assign match[i] = (LEN_W'(i) >= plen_eff) || (win_r[i] == pat_vec[8*i +: 8]);
  end

  assign st.full      = (LEN_W'(fill_r) == plen_eff);
  assign st.hit       = &match;
  assign st.fill_zero = (fill_r == '0);
  assign st.rc_last   = ((LEN_W'(rc_r) + LEN_W'(1)) == rlen_eff);
  assign st.rlen_zero = (rlen_eff == '0);
  assign st.slot_free = !out_valid_r || out_ready;

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.load) begin
      fill_nxt = FW'(wr_pos + LEN_W'(1));
    end else if (cmd.clr_fill) begin
      fill_nxt = '0;
    end else if (cmd.shift) begin
      fill_nxt = fill_r - FW'(1);
    end
    if (cfg_we && cfg_idx == CFG_PAT_LEN) begin
      fill_nxt = '0;
    end
    rc_nxt = rc_r;
    if (cmd.rc_clr) begin
      rc_nxt = '0;
    end else if (cmd.rc_inc) begin
      rc_nxt = rc_r + RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      rep_lo_r    <= '0;
      rep_hi_r    <= '0;
      plen_r      <= LEN_W'(1);
      rlen_r      <= '0;
      fill_r      <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      rc_r   <= rc_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PAT_LO:  pat_lo_r <= cfg_data;
          CFG_PAT_HI:  pat_hi_r <= cfg_data;
          CFG_PAT_LEN: plen_r   <= cfg_data[LEN_W-1:0];
          CFG_REP_LO:  rep_lo_r <= cfg_data;
          CFG_REP_HI:  rep_hi_r <= cfg_data;
          CFG_REP_LEN: rlen_r   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window: write at fill position, or shift toward slot zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (cmd.load && wr_pos == LEN_W'(i)) begin
        win_r[i] <= in_byte;
      end else if (cmd.shift && i < PATTERN_MAX - 1) begin
        win_r[i] <= win_r[(i + 1) % PATTERN_MAX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rl_r <= cmd.run_last;
      unique case (cmd.emit_sel)
        EMIT_WIN: begin
          out_byte_r <= win_r[0];
          out_bv_r   <= 1'b1;
          out_se_r   <= 1'b0;
        end
        EMIT_REP: begin
          out_byte_r <= rep_byte;
          out_bv_r   <= 1'b1;
          out_se_r   <= 1'b0;
        end
        default: begin
          out_byte_r <= '0;
          out_bv_r   <= 1'b0;
          out_se_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_run_last   = out_rl_r;
  assign out_stream_end = out_se_r;

endmodule

// ----- src/ssr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: accept, compare, replace burst, flush and end marker.
// ----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_end,
  output logic                 in_ready,
  input  ssr_pkg::ssr_status_t st,
  output ssr_pkg::ssr_cmd_t    cmd
);
  import ssr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_REPL,
    S_FLUSH,
    S_END
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    cmd          = '0;
    cmd.emit_sel = EMIT_WIN;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_end;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!st.full) begin
          state_nxt = last_r ? S_FLUSH : S_IDLE;
        end else if (st.hit) begin
          cmd.clr_fill = 1'b1;
          cmd.rc_clr   = 1'b1;
          if (st.rlen_zero) begin
            state_nxt = last_r ? S_END : S_IDLE;
          end else begin
            state_nxt = S_REPL;
          end
        end else if (st.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.shift    = 1'b1;
          cmd.run_last = !last_r;
          state_nxt    = last_r ? S_FLUSH : S_IDLE;
        end
      end
      S_REPL: begin
        if (st.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_REP;
          cmd.rc_inc   = 1'b1;
          cmd.run_last = st.rc_last && !last_r;
          if (st.rc_last) begin
            state_nxt = last_r ? S_END : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (st.fill_zero) begin
          state_nxt = S_END;
        end else if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
        end
      end
      S_END: begin
        if (st.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_END;
          cmd.run_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- tb/tb_stream_search_replace_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_search_replace_core
// Self-checking bench for the streaming search-and-replace core. A driver
// feeds bytes from a queue and a scoreboard predicts every output byte and
// end marker. The run covers several pattern and replacement settings and
// several idle and stall profiles on both channels.
// ----------------------------------------------------------------------------
module tb_stream_search_replace_core;
  import ssr_pkg::*;

  // Register indexes past the last defined one; the core must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

  localparam int WIN_MAX        = PATTERN_MAX_DEF;
  localparam int REP_MAX        = REPLACE_MAX_DEF;
  localparam int MAX_PER_BYTE   = WIN_MAX + 2;
  localparam int DRAIN_CYCLES   = 8;     // latency margin after the last result
  localparam int END_CYCLES     = 20;
  localparam int HOLD_CYCLES    = 150;   // long receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
  } feed_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              stream_end;
  } ssr_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ssr_in_if  in_if();
  ssr_out_if out_if();
  ssr_cfg_if cfg_if();

  stream_search_replace_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard state: a private copy of the registers and the match window.
  // --------------------------------------------------------------------------
  logic [8*WIN_MAX-1:0] pat_bytes;
  logic [8*REP_MAX-1:0] rep_bytes;
  logic [LEN_W-1:0]     pat_len_reg;
  logic [LEN_W-1:0]     rep_len_reg;
  logic [BYTE_W-1:0]    win_bytes [WIN_MAX];
  int                   win_count;

  feed_item_t  byte_feed_q[$];       // bytes waiting for the driver
  ssr_result_t predicted_out_q[$];   // results the core still owes us

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;   // bumped by the sequence to ask for a long stall
  int hold_ack       = 0;
  int hold_left      = 0;

  logic in_fire;
  int   mismatch_cnt = 0;
  int   in_count     = 0;
  int   out_count    = 0;
  int   cfg_count    = 0;
  int   marker_count = 0;
  int   idle_cycles  = 0;

  // Zero means one, anything past the window size saturates.
  function automatic int eff_pat_len();
    int p;
    p = int'(pat_len_reg);
    if (p < 1) p = 1;
    if (p > WIN_MAX) p = WIN_MAX;
    return p;
  endfunction

  function automatic ssr_result_t mk_result(logic [BYTE_W-1:0] b, logic bv, logic se);
    ssr_result_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.run_last   = 1'b0;
    r.stream_end = se;
    return r;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_PAT_LO:  pat_bytes[63:0]   = d;
      CFG_PAT_HI:  pat_bytes[127:64] = d;
      CFG_PAT_LEN: begin
        pat_len_reg = d[LEN_W-1:0];
        win_count   = 0;   // new length drops whatever was buffered
      end
      CFG_REP_LO:  rep_bytes[63:0]   = d;
      CFG_REP_HI:  rep_bytes[127:64] = d;
      CFG_REP_LEN: rep_len_reg = d[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Push one byte into the window and queue every result it causes.
  function automatic void predict_replace(logic [BYTE_W-1:0] b, logic last);
    ssr_result_t res [MAX_PER_BYTE];
    int          n;
    int          plen;
    int          rlen;
    int          i;
    logic        hit;
    n    = 0;
    plen = eff_pat_len();
    if (win_count >= plen) win_count = 0;
    win_bytes[win_count] = b;
    win_count++;
    if (win_count == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        rlen = (int'(rep_len_reg) > REP_MAX) ? REP_MAX : int'(rep_len_reg);
        for (i = 0; i < rlen; i++) begin
          res[n] = mk_result(rep_bytes[8*i +: 8], 1'b1, 1'b0);
          n++;
        end
        win_count = 0;
      end else begin
        res[n] = mk_result(win_bytes[0], 1'b1, 1'b0);
        n++;
        for (i = 0; i < WIN_MAX - 1; i++) win_bytes[i] = win_bytes[i+1];
        win_count--;
      end
    end
    if (last) begin
      for (i = 0; i < win_count; i++) begin
        res[n] = mk_result(win_bytes[i], 1'b1, 1'b0);
        n++;
      end
      win_count = 0;
      res[n] = mk_result('0, 1'b0, 1'b1);
      n++;
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    for (i = 0; i < n; i++) predicted_out_q.push_back(res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the next queued byte at the falling edge. A byte on the
  // bus stays put until its transaction completes.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (byte_feed_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= byte_feed_q[0].in_byte;
        in_if.end_of_input <= byte_feed_q[0].end_of_input;
        byte_feed_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request, counted here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      out_if.ready <= 1'b0;
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every transaction is observed at the rising edge. Input bytes go
  // to the predictor, config writes update the shadow registers, results are
  // checked in order against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ssr_result_t want;
    in_fire = rst_n && (in_if.valid === 1'b1) && (in_if.ready === 1'b1);
    if (in_fire) begin
      predict_replace(in_if.in_byte, in_if.end_of_input);
      in_count++;
    end
    if (rst_n && (cfg_if.valid === 1'b1) && (cfg_if.ready === 1'b1)) begin
      apply_cfg(cfg_if.index, cfg_if.data);
      cfg_count++;
    end
    if (rst_n && (out_if.valid === 1'b1) && (out_if.ready === 1'b1)) begin
      out_count++;
      if (out_if.stream_end === 1'b1) marker_count++;
      if (predicted_out_q.size() == 0) begin
        if (mismatch_cnt < REPORT_MAX)
          $display("[%0t] unexpected result: byte=%02h bv=%0b last=%0b end=%0b", $time,
                   out_if.out_byte, out_if.byte_valid, out_if.run_last, out_if.stream_end);
        mismatch_cnt++;
      end else begin
        want = predicted_out_q.pop_front();
        if (out_if.out_byte !== want.out_byte || out_if.byte_valid !== want.byte_valid ||
            out_if.run_last !== want.run_last || out_if.stream_end !== want.stream_end) begin
          if (mismatch_cnt < REPORT_MAX)
            $display({"[%0t] mismatch: exp byte=%02h bv=%0b last=%0b end=%0b",
                      " / got byte=%02h bv=%0b last=%0b end=%0b"},
                     $time, want.out_byte, want.byte_valid, want.run_last, want.stream_end,
                     out_if.out_byte, out_if.byte_valid, out_if.run_last, out_if.stream_end);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on any channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, predicted_out_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  function automatic void push_item(logic [BYTE_W-1:0] b, logic last);
    feed_item_t it;
    it.in_byte      = b;
    it.end_of_input = last;
    byte_feed_q.push_back(it);
  endfunction

  // Idle = all bytes taken and all results back, plus a latency margin for
  // bytes that produced nothing but may still be in flight.
  task automatic wait_idle();
    @(posedge clk);
    while (byte_feed_q.size() != 0 || in_if.valid || predicted_out_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Streams built mostly from whole pattern copies, with broken prefixes,
  // stray pattern bytes and plain noise mixed in. Each ends with the flag.
  task automatic gen_streams(int target);
    logic [BYTE_W-1:0] sbuf[$];
    int made;
    int kind;
    int plen;
    int k;
    int cut;
    made = 0;
    plen = eff_pat_len();
    while (made < target) begin
      sbuf.delete();
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          for (k = 0; k < plen; k++) sbuf.push_back(pat_bytes[8*k +: 8]);
        end else if (kind < 55 && plen > 1) begin
          cut = $urandom_range(1, plen - 1);
          for (k = 0; k < cut; k++) sbuf.push_back(pat_bytes[8*k +: 8]);
        end else if (kind < 75) begin
          k = $urandom_range(0, plen - 1);
          sbuf.push_back(pat_bytes[8*k +: 8]);
        end else begin
          sbuf.push_back(BYTE_W'($urandom_range(0, 255)));
        end
      end
      for (k = 0; k < sbuf.size(); k++) push_item(sbuf[k], k == sbuf.size() - 1);
      made += sbuf.size();
    end
  endtask

  task automatic write_pattern(int plen_val, int rlen_val);
    cfg_write(CFG_PAT_LO, rand64());
    cfg_write(CFG_PAT_HI, rand64());
    cfg_write(CFG_PAT_LEN, CFG_DATA_W'(plen_val));
    cfg_write(CFG_REP_LO, rand64());
    cfg_write(CFG_REP_HI, rand64());
    cfg_write(CFG_REP_LEN, CFG_DATA_W'(rlen_val));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    pat_bytes          = '0;
    rep_bytes          = '0;
    pat_len_reg        = LEN_W'(1);
    rep_len_reg        = '0;
    win_count          = 0;
    for (int i = 0; i < WIN_MAX; i++) win_bytes[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-byte pattern 00 with an empty replacement, so a
    // zero byte vanishes and anything else passes.
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    wait_idle();

    // Pattern "ABC" with junk above the used bytes, replacement "xy".
    cfg_write(CFG_PAT_LO, {40'(rand64()), 24'h434241});
    cfg_write(CFG_PAT_HI, rand64());
    cfg_write(CFG_PAT_LEN, 64'd3);
    cfg_write(CFG_REP_LO, {48'(rand64()), 16'h7978});
    cfg_write(CFG_REP_HI, rand64());
    cfg_write(CFG_REP_LEN, 64'd2);
    cfg_write(CFG_UNUSED_A, rand64());   // out-of-range index: no effect
    cfg_write(CFG_UNUSED_B, rand64());

    // Plain match, then a match that ends on the final byte.
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    push_item(8'h43, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    push_item(8'h43, 1'b1);
    wait_idle();

    // Replacement rewritten with two bytes buffered: they survive.
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    wait_idle();
    cfg_write(CFG_REP_LO, rand64());
    push_item(8'h43, 1'b0);
    // Pattern length rewritten with two bytes buffered: they are dropped.
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    wait_idle();
    cfg_write(CFG_PAT_LEN, 64'd3);
    push_item(8'h43, 1'b1);
    wait_idle();

    // Length zero acts as one; an oversized replacement length saturates,
    // so one match yields the full burst plus the marker.
    cfg_write(CFG_PAT_LEN, 64'd0);
    cfg_write(CFG_REP_LEN, 64'd20);
    push_item(8'h41, 1'b1);
    push_item(8'h42, 1'b1);
    wait_idle();

    // Phase 1: no idling, short pattern. The receiver holds off for a long
    // stretch while bytes keep coming, so the core has to stall its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_pattern($urandom_range(2, 4), $urandom_range(1, 5));
    hold_req++;
    gen_streams(50);
    wait_idle();

    // Phase 2: sender idle most cycles, widest window and burst (sometimes
    // via oversized length values).
    send_idle_pct  = 64;
    recv_stall_pct = 0;
    write_pattern(($urandom_range(0, 1) != 0) ? 16 : $urandom_range(17, 31),
                  ($urandom_range(0, 1) != 0) ? 16 : $urandom_range(17, 31));
    gen_streams(50);
    wait_idle();

    // Phase 3: receiver stalls most cycles, one-byte pattern deleted outright.
    send_idle_pct  = 0;
    recv_stall_pct = 64;
    write_pattern(1, 0);
    gen_streams(50);
    wait_idle();

    // Phase 4: light idling on both sides, sender pauses mid-phase until the
    // core has drained completely.
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    write_pattern($urandom_range(3, 8), $urandom_range(0, 16));
    gen_streams(25);
    wait_idle();
    gen_streams(25);
    wait_idle();

    repeat (END_CYCLES) @(posedge clk);
    if (predicted_out_q.size() != 0) begin
      $display("%0d predicted results never arrived", predicted_out_q.size());
      mismatch_cnt += predicted_out_q.size();
    end

    $display("Run: %0d input and %0d output transactions, %0d end markers, %0d config writes",
             in_count, out_count, marker_count, cfg_count);
    $display("     pattern lengths 0..31, four idle/stall profiles, %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ssr_pkg.sv
src/ssr_in_if.sv
src/ssr_out_if.sv
src/ssr_cfg_if.sv
src/ssr_datapath.sv
src/ssr_ctrl.sv
src/stream_search_replace_core.sv
tb/tb_stream_search_replace_core.sv
